/* design/lobm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_pkg
// Shared constants, codes and controller/datapath interface types for the
// limit order book matcher.
// ----------------------------------------------------------------------------
package lobm_pkg;

    localparam int PRICE_LEVELS = 256;
    localparam int ORDER_SLOTS  = 32;
    localparam int QTY_BITS     = 20;

    localparam int LVL_BITS  = $clog2(PRICE_LEVELS);
    localparam int SLOT_BITS = $clog2(ORDER_SLOTS);
    localparam int K_BITS    = $clog2(ORDER_SLOTS + 1);
    localparam int LV_W      = 2 * SLOT_BITS;

    localparam int ID_W   = 31;
    localparam int PX_W   = 8;
    localparam int QTY_W  = 20;
    localparam int KIND_W = 3;
    localparam int TYPE_W = 2;

    localparam logic [TYPE_W-1:0] REQ_BUY_ADD     = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_BUY_CANCEL  = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_SELL_ADD    = 2'd2;
    localparam logic [TYPE_W-1:0] REQ_SELL_CANCEL = 2'd3;

    typedef enum logic [KIND_W-1:0] {
        EV_TRADE,
        EV_RESTED,
        EV_NOT_RESTED,
        EV_CANCEL_OK,
        EV_CANCEL_FAIL,
        EV_REJECT_FULL
    } event_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAT,
        ST_FILL,
        ST_NEXT,
        ST_FRD,
        ST_FWR,
        ST_CRD,
        ST_CLAT,
        ST_CWALK
    } state_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_STEP,
        CMD_LV_RD,
        CMD_LV_LATCH,
        CMD_FILL,
        CMD_F_RD,
        CMD_FINAL,
        CMD_C_RD,
        CMD_C_LATCH,
        CMD_C_STEP
    } cmd_t;

    typedef struct packed {
        cmd_t cmd;
    } ctrl_cmd_t;

    typedef struct packed {
        logic req_cancel;
        logic live_p;
        logic live_px;
        logic rem_zero;
        logic k_full;
        logic at_limit;
        logic id_match;
        logic s_tail;
    } dp_status_t;

endpackage

/* design/limit_order_book_matcher_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limit_order_book_matcher_core
// Two-sided price-time priority order book: adds match against the opposite
// side, remainders rest in FIFO per level, cancels unlink by id.
// ----------------------------------------------------------------------------
// Channel   Handshake              Fields
// request   start & !busy          req_type, order_id, price_tick, order_qty
// result    result_valid (1 cyc)   event_kind, buyer_id, seller_id,
//                                  trade_price, trade_qty, last_of_run
//
// Add: steps over empty levels, opens a live level by reading and latching
// its level table entry, fills, then finishes with a read and a write; up to
// 256 levels and 32 fills. Cancel: read, latch, then walk the FIFO by entry.
// Reset clears live and free bits at once; no clearing pass.
// Results cannot be stalled; the next request is taken as the final result
// is shown.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [lobm_pkg::TYPE_W-1:0]   req_type,
    input  logic [lobm_pkg::ID_W-1:0]     order_id,
    input  logic [lobm_pkg::PX_W-1:0]     price_tick,
    input  logic [lobm_pkg::QTY_W-1:0]    order_qty,
    output logic                          result_valid,
    output logic [lobm_pkg::KIND_W-1:0]   event_kind,
    output logic [lobm_pkg::ID_W-1:0]     buyer_id,
    output logic [lobm_pkg::ID_W-1:0]     seller_id,
    output logic [lobm_pkg::PX_W-1:0]     trade_price,
    output logic [lobm_pkg::QTY_W-1:0]    trade_qty,
    output logic                          last_of_run
);
    import lobm_pkg::*;

    ctrl_cmd_t  ctrl;
    dp_status_t status;

    lobm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .ctrl   (ctrl),
        .busy   (busy)
    );

    lobm_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .req_type     (req_type),
        .order_id     (order_id),
        .price_tick   (price_tick),
        .order_qty    (order_qty),
        .status       (status),
        .result_valid (result_valid),
        .event_kind   (event_kind),
        .buyer_id     (buyer_id),
        .seller_id    (seller_id),
        .trade_price  (trade_price),
        .trade_qty    (trade_qty),
        .last_of_run  (last_of_run)
    );

endmodule

/* design/lobm_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module lobm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/lobm_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_ctrl
// Sequencer: walks levels and FIFO entries, issues one datapath command per
// cycle.
// ----------------------------------------------------------------------------
module lobm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  lobm_pkg::dp_status_t status,
    output lobm_pkg::ctrl_cmd_t  ctrl,
    output logic                busy
);
    import lobm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl.cmd   = CMD_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctrl.cmd   = CMD_LOAD;
                    state_next = status.req_cancel ? ST_CRD : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.rem_zero || status.k_full)
                begin
                    state_next = ST_FRD;
                end
                else if (status.live_p)
                begin
                    ctrl.cmd   = CMD_LV_RD;
                    state_next = ST_LAT;
                end
                else if (status.at_limit)
                begin
                    state_next = ST_FRD;
                end
                else
                begin
                    ctrl.cmd = CMD_STEP;
                end
            end
            ST_LAT:
            begin
                ctrl.cmd   = CMD_LV_LATCH;
                state_next = ST_FILL;
            end
            ST_FILL:
            begin
                ctrl.cmd   = CMD_FILL;
                state_next = ST_NEXT;
            end
            ST_NEXT:
            begin
                if (status.rem_zero || status.k_full)
                begin
                    state_next = ST_FRD;
                end
                else if (status.live_p)
                begin
                    state_next = ST_FILL;
                end
                else if (status.at_limit)
                begin
                    state_next = ST_FRD;
                end
                else
                begin
                    ctrl.cmd   = CMD_STEP;
                    state_next = ST_SCAN;
                end
            end
            ST_FRD:
            begin
                ctrl.cmd   = CMD_F_RD;
                state_next = ST_FWR;
            end
            ST_FWR:
            begin
                ctrl.cmd   = CMD_FINAL;
                state_next = ST_IDLE;
            end
            ST_CRD:
            begin
                ctrl.cmd   = CMD_C_RD;
                state_next = ST_CLAT;
            end
            ST_CLAT:
            begin
                ctrl.cmd   = CMD_C_LATCH;
                state_next = status.live_px ? ST_CWALK : ST_IDLE;
            end
            ST_CWALK:
            begin
                ctrl.cmd = CMD_C_STEP;
                if (status.id_match || status.s_tail)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

/* design/lobm_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_dpath
// Book storage and request registers: slot stores, links, level tables,
// live and free bits, result register.
// ----------------------------------------------------------------------------
module lobm_dpath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lobm_pkg::ctrl_cmd_t           ctrl,
    input  logic [lobm_pkg::TYPE_W-1:0]   req_type,
    input  logic [lobm_pkg::ID_W-1:0]     order_id,
    input  logic [lobm_pkg::PX_W-1:0]     price_tick,
    input  logic [lobm_pkg::QTY_W-1:0]    order_qty,
    output lobm_pkg::dp_status_t          status,
    output logic                          result_valid,
    output logic [lobm_pkg::KIND_W-1:0]   event_kind,
    output logic [lobm_pkg::ID_W-1:0]     buyer_id,
    output logic [lobm_pkg::ID_W-1:0]     seller_id,
    output logic [lobm_pkg::PX_W-1:0]     trade_price,
    output logic [lobm_pkg::QTY_W-1:0]    trade_qty,
    output logic                          last_of_run
);
    import lobm_pkg::*;

    logic [TYPE_W-1:0]    type_reg;
    logic [ID_W-1:0]      id_reg;
    logic [LVL_BITS-1:0]  px_reg;
    logic [QTY_BITS-1:0]  rem_reg;
    logic [QTY_BITS-1:0]  rem_next;
    logic [LVL_BITS-1:0]  p_reg;
    logic [LVL_BITS-1:0]  p_next;
    logic [K_BITS-1:0]    k_reg;
    logic [K_BITS-1:0]    k_next;
    logic [SLOT_BITS-1:0] head_reg;
    logic [SLOT_BITS-1:0] head_next;
    logic [SLOT_BITS-1:0] tail_reg;
    logic [SLOT_BITS-1:0] tail_next;
    logic [SLOT_BITS-1:0] s_reg;
    logic [SLOT_BITS-1:0] s_next;
    logic [SLOT_BITS-1:0] prev_reg;
    logic [SLOT_BITS-1:0] prev_next;
    logic                 prev_vld_reg;
    logic                 prev_vld_next;

    logic [ID_W-1:0]      bid_id_reg  [ORDER_SLOTS];
    logic [QTY_BITS-1:0]  bid_qty_reg [ORDER_SLOTS];
    logic [SLOT_BITS-1:0] bid_nxt_reg [ORDER_SLOTS];
    logic [ID_W-1:0]      ask_id_reg  [ORDER_SLOTS];
    logic [QTY_BITS-1:0]  ask_qty_reg [ORDER_SLOTS];
    logic [SLOT_BITS-1:0] ask_nxt_reg [ORDER_SLOTS];

    logic [PRICE_LEVELS-1:0] bid_live_reg;
    logic [PRICE_LEVELS-1:0] ask_live_reg;
    logic [ORDER_SLOTS-1:0]  bid_free_reg;
    logic [ORDER_SLOTS-1:0]  ask_free_reg;

    logic                 res_vld_reg;
    logic                 res_vld_next;
    logic [KIND_W-1:0]    kind_reg;
    logic [KIND_W-1:0]    kind_next;
    logic [ID_W-1:0]      buyer_reg;
    logic [ID_W-1:0]      buyer_next;
    logic [ID_W-1:0]      seller_reg;
    logic [ID_W-1:0]      seller_next;
    logic [PX_W-1:0]      price_reg;
    logic [PX_W-1:0]      price_next;
    logic [QTY_W-1:0]     qty_reg;
    logic [QTY_W-1:0]     qty_next;
    logic                 last_reg;
    logic                 last_next;

    logic                 buying;
    logic                 own;
    logic                 opp;
    logic                 acc_side;
    logic [SLOT_BITS-1:0] acc_slot;
    logic [ID_W-1:0]      cur_id;
    logic [QTY_BITS-1:0]  cur_qty;
    logic [SLOT_BITS-1:0] cur_nxt;
    logic [QTY_BITS-1:0]  fill_qty;
    logic [LV_W-1:0]      bid_rdata;
    logic [LV_W-1:0]      ask_rdata;
    logic [LV_W-1:0]      own_lv;
    logic [LV_W-1:0]      opp_lv;
    logic [ORDER_SLOTS-1:0] free_own;
    logic [SLOT_BITS-1:0] free_idx;
    logic [LVL_BITS-1:0]  px_in;

    logic [LVL_BITS-1:0]  rd_addr;
    logic                 lv_we;
    logic                 lv_side;
    logic [LVL_BITS-1:0]  lv_waddr;
    logic [LV_W-1:0]      lv_wdata;

    logic                 id_we;
    logic                 qty_we;
    logic [QTY_BITS-1:0]  qty_wdata;
    logic                 nxt0_we;
    logic [SLOT_BITS-1:0] nxt0_addr;
    logic [SLOT_BITS-1:0] nxt0_data;
    logic                 nxt1_we;
    logic [SLOT_BITS-1:0] nxt1_addr;
    logic [SLOT_BITS-1:0] nxt1_data;
    logic [SLOT_BITS-1:0] wr_slot;
    logic                 live_we;
    logic                 live_val;
    logic [LVL_BITS-1:0]  live_addr;
    logic                 take_we;
    logic                 give_we;
    logic [SLOT_BITS-1:0] give_slot;

    assign buying   = (type_reg == REQ_BUY_ADD) || (type_reg == REQ_BUY_CANCEL);
    assign own      = !buying;
    assign opp      = buying;
    assign acc_side = (ctrl.cmd == CMD_FILL) ? opp : own;
    assign acc_slot = (ctrl.cmd == CMD_FILL) ? head_reg : s_reg;
    assign cur_id   = acc_side ? ask_id_reg[acc_slot]  : bid_id_reg[acc_slot];
    assign cur_qty  = acc_side ? ask_qty_reg[acc_slot] : bid_qty_reg[acc_slot];
    assign cur_nxt  = acc_side ? ask_nxt_reg[acc_slot] : bid_nxt_reg[acc_slot];
    assign fill_qty = (cur_qty < rem_reg) ? cur_qty : rem_reg;
    assign own_lv   = own ? ask_rdata : bid_rdata;
    assign opp_lv   = opp ? ask_rdata : bid_rdata;
    assign free_own = own ? ask_free_reg : bid_free_reg;

    always_comb
    begin
        free_idx = '0;
        for (int i = ORDER_SLOTS - 1; i >= 0; i--)
        begin
            if (free_own[i])
            begin
                free_idx = SLOT_BITS'(i);
            end
        end
    end

    always_comb
    begin
        if (32'(price_tick) >= 32'(PRICE_LEVELS))
        begin
            px_in = LVL_BITS'(PRICE_LEVELS - 1);
        end
        else
        begin
            px_in = LVL_BITS'(price_tick);
        end
    end

    assign status.req_cancel = (req_type == REQ_BUY_CANCEL) || (req_type == REQ_SELL_CANCEL);
    assign status.live_p     = opp ? ask_live_reg[p_reg] : bid_live_reg[p_reg];
    assign status.live_px    = own ? ask_live_reg[px_reg] : bid_live_reg[px_reg];
    assign status.rem_zero   = (rem_reg == '0);
    assign status.k_full     = (k_reg == K_BITS'(ORDER_SLOTS));
    assign status.at_limit   = (p_reg == px_reg);
    assign status.id_match   = (cur_id == id_reg);
    assign status.s_tail     = (tail_reg == acc_slot);

    always_comb
    begin
        rem_next      = rem_reg;
        p_next        = p_reg;
        k_next        = k_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        s_next        = s_reg;
        prev_next     = prev_reg;
        prev_vld_next = prev_vld_reg;
        rd_addr       = px_reg;
        lv_we         = 1'b0;
        lv_side       = own;
        lv_waddr      = px_reg;
        lv_wdata      = '0;
        id_we         = 1'b0;
        qty_we        = 1'b0;
        qty_wdata     = rem_reg;
        nxt0_we       = 1'b0;
        nxt0_addr     = free_idx;
        nxt0_data     = free_idx;
        nxt1_we       = 1'b0;
        nxt1_addr     = own_lv[SLOT_BITS-1:0];
        nxt1_data     = free_idx;
        wr_slot       = free_idx;
        live_we       = 1'b0;
        live_val      = 1'b0;
        live_addr     = px_reg;
        take_we       = 1'b0;
        give_we       = 1'b0;
        give_slot     = acc_slot;
        res_vld_next  = 1'b0;
        kind_next     = kind_reg;
        buyer_next    = id_reg;
        seller_next   = id_reg;
        price_next    = PX_W'(px_reg);
        qty_next      = '0;
        last_next     = 1'b1;
        case (ctrl.cmd)
            CMD_LOAD:
            begin
                rem_next      = QTY_BITS'(order_qty);
                k_next        = '0;
                prev_vld_next = 1'b0;
                if ((req_type == REQ_BUY_ADD) || (req_type == REQ_BUY_CANCEL))
                begin
                    p_next = '0;
                end
                else
                begin
                    p_next = LVL_BITS'(PRICE_LEVELS - 1);
                end
            end
            CMD_STEP:
            begin
                p_next = buying ? (p_reg + LVL_BITS'(1)) : (p_reg - LVL_BITS'(1));
            end
            CMD_LV_RD:
            begin
                rd_addr = p_reg;
            end
            CMD_LV_LATCH:
            begin
                head_next = opp_lv[LV_W-1:SLOT_BITS];
                tail_next = opp_lv[SLOT_BITS-1:0];
            end
            CMD_FILL:
            begin
                rem_next     = rem_reg - fill_qty;
                k_next       = k_reg + K_BITS'(1);
                qty_we       = 1'b1;
                qty_wdata    = cur_qty - fill_qty;
                wr_slot      = head_reg;
                res_vld_next = 1'b1;
                kind_next    = EV_TRADE;
                buyer_next   = buying ? id_reg : cur_id;
                seller_next  = buying ? cur_id : id_reg;
                price_next   = PX_W'(p_reg);
                qty_next     = QTY_W'(fill_qty);
                last_next    = 1'b0;
                if (cur_qty == fill_qty)
                begin
                    give_we = 1'b1;
                    if (tail_reg == head_reg)
                    begin
                        live_we   = 1'b1;
                        live_val  = 1'b0;
                        live_addr = p_reg;
                    end
                    else
                    begin
                        head_next = cur_nxt;
                        lv_we     = 1'b1;
                        lv_side   = opp;
                        lv_waddr  = p_reg;
                        lv_wdata  = {cur_nxt, tail_reg};
                    end
                end
            end
            CMD_F_RD:
            begin
                rd_addr = px_reg;
            end
            CMD_FINAL:
            begin
                res_vld_next = 1'b1;
                qty_next     = QTY_W'(rem_reg);
                if (rem_reg == '0)
                begin
                    kind_next = EV_NOT_RESTED;
                end
                else if (free_own != '0)
                begin
                    kind_next = EV_RESTED;
                    id_we     = 1'b1;
                    qty_we    = 1'b1;
                    nxt0_we   = 1'b1;
                    take_we   = 1'b1;
                    lv_we     = 1'b1;
                    if (status.live_px)
                    begin
                        nxt1_we  = 1'b1;
                        lv_wdata = {own_lv[LV_W-1:SLOT_BITS], free_idx};
                    end
                    else
                    begin
                        lv_wdata = {free_idx, free_idx};
                        live_we  = 1'b1;
                        live_val = 1'b1;
                    end
                end
                else
                begin
                    kind_next = EV_REJECT_FULL;
                end
            end
            CMD_C_RD:
            begin
                rd_addr = px_reg;
            end
            CMD_C_LATCH:
            begin
                head_next     = own_lv[LV_W-1:SLOT_BITS];
                tail_next     = own_lv[SLOT_BITS-1:0];
                s_next        = own_lv[LV_W-1:SLOT_BITS];
                prev_vld_next = 1'b0;
                if (!status.live_px)
                begin
                    res_vld_next = 1'b1;
                    kind_next    = EV_CANCEL_FAIL;
                end
            end
            CMD_C_STEP:
            begin
                if (status.id_match)
                begin
                    res_vld_next = 1'b1;
                    kind_next    = EV_CANCEL_OK;
                    qty_next     = QTY_W'(cur_qty);
                    give_we      = 1'b1;
                    if (!prev_vld_reg)
                    begin
                        if (status.s_tail)
                        begin
                            live_we  = 1'b1;
                            live_val = 1'b0;
                        end
                        else
                        begin
                            lv_we    = 1'b1;
                            lv_wdata = {cur_nxt, tail_reg};
                        end
                    end
                    else
                    begin
                        nxt1_we   = 1'b1;
                        nxt1_addr = prev_reg;
                        nxt1_data = cur_nxt;
                        if (status.s_tail)
                        begin
                            lv_we    = 1'b1;
                            lv_wdata = {head_reg, prev_reg};
                        end
                    end
                end
                else if (status.s_tail)
                begin
                    res_vld_next = 1'b1;
                    kind_next    = EV_CANCEL_FAIL;
                end
                else
                begin
                    prev_next     = s_reg;
                    prev_vld_next = 1'b1;
                    s_next        = cur_nxt;
                end
            end
            default:
            begin
            end
        endcase
    end

    lobm_ram #(
        .WIDTH (LV_W),
        .DEPTH (PRICE_LEVELS)
    ) u_bid_lv (
        .clk   (clk),
        .we    (lv_we && !lv_side),
        .waddr (lv_waddr),
        .wdata (lv_wdata),
        .raddr (rd_addr),
        .rdata (bid_rdata)
    );

    lobm_ram #(
        .WIDTH (LV_W),
        .DEPTH (PRICE_LEVELS)
    ) u_ask_lv (
        .clk   (clk),
        .we    (lv_we && lv_side),
        .waddr (lv_waddr),
        .wdata (lv_wdata),
        .raddr (rd_addr),
        .rdata (ask_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (acc_side)
        begin
            if (id_we)
            begin
                ask_id_reg[wr_slot] <= id_reg;
            end
            if (qty_we)
            begin
                ask_qty_reg[wr_slot] <= qty_wdata;
            end
            if (nxt0_we)
            begin
                ask_nxt_reg[nxt0_addr] <= nxt0_data;
            end
            if (nxt1_we)
            begin
                ask_nxt_reg[nxt1_addr] <= nxt1_data;
            end
        end
        else
        begin
            if (id_we)
            begin
                bid_id_reg[wr_slot] <= id_reg;
            end
            if (qty_we)
            begin
                bid_qty_reg[wr_slot] <= qty_wdata;
            end
            if (nxt0_we)
            begin
                bid_nxt_reg[nxt0_addr] <= nxt0_data;
            end
            if (nxt1_we)
            begin
                bid_nxt_reg[nxt1_addr] <= nxt1_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bid_live_reg <= '0;
            ask_live_reg <= '0;
            bid_free_reg <= '1;
            ask_free_reg <= '1;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            res_vld_reg <= res_vld_next;
            if (live_we)
            begin
                if (acc_side)
                begin
                    ask_live_reg[live_addr] <= live_val;
                end
                else
                begin
                    bid_live_reg[live_addr] <= live_val;
                end
            end
            if (give_we)
            begin
                if (acc_side)
                begin
                    ask_free_reg[give_slot] <= 1'b1;
                end
                else
                begin
                    bid_free_reg[give_slot] <= 1'b1;
                end
            end
            if (take_we)
            begin
                if (acc_side)
                begin
                    ask_free_reg[free_idx] <= 1'b0;
                end
                else
                begin
                    bid_free_reg[free_idx] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.cmd == CMD_LOAD)
        begin
            type_reg <= req_type;
            id_reg   <= order_id;
            px_reg   <= px_in;
        end
        rem_reg      <= rem_next;
        p_reg        <= p_next;
        k_reg        <= k_next;
        head_reg     <= head_next;
        tail_reg     <= tail_next;
        s_reg        <= s_next;
        prev_reg     <= prev_next;
        prev_vld_reg <= prev_vld_next;
        kind_reg     <= kind_next;
        buyer_reg    <= buyer_next;
        seller_reg   <= seller_next;
        price_reg    <= price_next;
        qty_reg      <= qty_next;
        last_reg     <= last_next;
    end

    assign result_valid = res_vld_reg;
    assign event_kind   = kind_reg;
    assign buyer_id     = buyer_reg;
    assign seller_id    = seller_reg;
    assign trade_price  = price_reg;
    assign trade_qty    = qty_reg;
    assign last_of_run  = last_reg;

endmodule

/* design/lobm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_checker
// Port-level checks on request and result sequencing.
// ----------------------------------------------------------------------------
module lobm_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          result_valid,
    input logic [lobm_pkg::KIND_W-1:0]   event_kind,
    input logic                          last_of_run
);
    import lobm_pkg::*;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_of_run |-> busy)
        else $error("non-final result outside a run");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_of_run |-> !busy)
        else $error("final result while still busy");

    a_trade_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (event_kind == EV_TRADE) |-> !last_of_run)
        else $error("trade marked final");

    a_cancel_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && ((event_kind == EV_CANCEL_OK) || (event_kind == EV_CANCEL_FAIL))
        |-> last_of_run)
        else $error("cancel result not final");

endmodule

bind limit_order_book_matcher_core lobm_checker u_lobm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .event_kind   (event_kind),
    .last_of_run  (last_of_run)
);

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the order book matcher: a queue-fed driver issues
// add/cancel requests, a monitor checks every result against an in-bench
// price-time priority book model.
// ----------------------------------------------------------------------------
module tb_top;
    import lobm_pkg::*;

    localparam int NSLOT = ORDER_SLOTS;
    localparam int NLVL  = PRICE_LEVELS;

    typedef struct packed {
        logic [TYPE_W-1:0] rtype;
        logic [ID_W-1:0]   id;
        logic [PX_W-1:0]   px;
        logic [QTY_W-1:0]  qty;
    } order_req_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   buyer;
        logic [ID_W-1:0]   seller;
        logic [PX_W-1:0]   price;
        logic [QTY_W-1:0]  qty;
        logic              last;
    } book_event_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [TYPE_W-1:0] req_type;
    logic [ID_W-1:0]   order_id;
    logic [PX_W-1:0]   price_tick;
    logic [QTY_W-1:0]  order_qty;
    logic result_valid;
    logic [KIND_W-1:0] event_kind;
    logic [ID_W-1:0]   buyer_id;
    logic [ID_W-1:0]   seller_id;
    logic [PX_W-1:0]   trade_price;
    logic [QTY_W-1:0]  trade_qty;
    logic last_of_run;

    limit_order_book_matcher_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .order_id(order_id), .price_tick(price_tick),
        .order_qty(order_qty), .result_valid(result_valid),
        .event_kind(event_kind), .buyer_id(buyer_id), .seller_id(seller_id),
        .trade_price(trade_price), .trade_qty(trade_qty),
        .last_of_run(last_of_run)
    );

    // book model, side 0 bid, side 1 ask
    logic [ID_W-1:0]  m_id   [2][NSLOT];
    logic [QTY_W-1:0] m_qty  [2][NSLOT];
    int               m_next [2][NSLOT];
    int               m_head [2][NLVL];
    int               m_tail [2][NLVL];
    bit               m_live [2][NLVL];
    bit               m_free [2][NSLOT];

    order_req_t  pending_orders[$];
    book_event_t expected_events[$];
    int errors = 0;
    int sent_cnt = 0;
    bit accepted;

    function automatic book_event_t mk_event(logic [KIND_W-1:0] k, logic [ID_W-1:0] b,
            logic [ID_W-1:0] s, logic [PX_W-1:0] p, logic [QTY_W-1:0] q, logic l);
        book_event_t e;
        e.kind = k; e.buyer = b; e.seller = s; e.price = p; e.qty = q; e.last = l;
        return e;
    endfunction

    function automatic void expect_evt(book_event_t e);
        expected_events.insert(expected_events.size(), e);
    endfunction

    function automatic void queue_req(order_req_t r);
        pending_orders.insert(pending_orders.size(), r);
    endfunction

    task automatic book_reset();
        for (int sd = 0; sd < 2; sd++)
        begin
            for (int i = 0; i < NSLOT; i++)
                m_free[sd][i] = 1;
            for (int i = 0; i < NLVL; i++)
                m_live[sd][i] = 0;
        end
    endtask

    task automatic book_match(input order_req_t r);
        int own;
        int opp;
        int k;
        int s;
        int p;
        int prev;
        bit buying;
        bit done;
        logic [QTY_W-1:0] rem;
        logic [QTY_W-1:0] f;
        k = 0;
        buying = (r.rtype[1] == 1'b0);
        own = buying ? 0 : 1;
        opp = 1 - own;
        rem = r.qty;
        if (r.rtype[0])
        begin
            done = 0;
            p = r.px;
            if (m_live[own][p])
            begin
                s = m_head[own][p];
                prev = -1;
                for (int n = 0; n < NSLOT && !done; n++)
                begin
                    if (m_id[own][s] == r.id)
                    begin
                        if (prev < 0)
                        begin
                            if (m_tail[own][p] == s) m_live[own][p] = 0;
                            else m_head[own][p] = m_next[own][s];
                        end
                        else
                        begin
                            m_next[own][prev] = m_next[own][s];
                            if (m_tail[own][p] == s) m_tail[own][p] = prev;
                        end
                        m_free[own][s] = 1;
                        expect_evt(mk_event(EV_CANCEL_OK, r.id, r.id,
                            r.px, m_qty[own][s], 1'b1));
                        done = 1;
                    end
                    else if (m_tail[own][p] == s) n = NSLOT;
                    else
                    begin
                        prev = s;
                        s = m_next[own][s];
                    end
                end
            end
            if (!done)
                expect_evt(mk_event(EV_CANCEL_FAIL, r.id, r.id, r.px, '0, 1'b1));
            return;
        end
        p = buying ? 0 : NLVL - 1;
        while (rem != 0 && (buying ? p <= int'(r.px) : p >= int'(r.px)))
        begin
            while (m_live[opp][p] && rem != 0 && k < NSLOT)
            begin
                s = m_head[opp][p];
                f = (m_qty[opp][s] < rem) ? m_qty[opp][s] : rem;
                rem -= f;
                m_qty[opp][s] -= f;
                if (buying)
                    expect_evt(mk_event(EV_TRADE, r.id, m_id[opp][s], PX_W'(p), f, 1'b0));
                else
                    expect_evt(mk_event(EV_TRADE, m_id[opp][s], r.id, PX_W'(p), f, 1'b0));
                k++;
                if (m_qty[opp][s] == 0)
                begin
                    m_free[opp][s] = 1;
                    if (m_tail[opp][p] == s) m_live[opp][p] = 0;
                    else m_head[opp][p] = m_next[opp][s];
                end
            end
            p = buying ? p + 1 : p - 1;
        end
        if (rem == 0)
            expect_evt(mk_event(EV_NOT_RESTED, r.id, r.id, r.px, '0, 1'b1));
        else
        begin
            s = -1;
            for (int i = 0; i < NSLOT && s < 0; i++)
                if (m_free[own][i]) s = i;
            if (s < 0)
                expect_evt(mk_event(EV_REJECT_FULL, r.id, r.id, r.px, rem, 1'b1));
            else
            begin
                m_free[own][s] = 0;
                m_id[own][s] = r.id;
                m_qty[own][s] = rem;
                m_next[own][s] = s;
                if (m_live[own][r.px])
                begin
                    m_next[own][m_tail[own][r.px]] = s;
                    m_tail[own][r.px] = s;
                end
                else
                begin
                    m_head[own][r.px] = s;
                    m_tail[own][r.px] = s;
                    m_live[own][r.px] = 1;
                end
                expect_evt(mk_event(EV_RESTED, r.id, r.id, r.px, rem, 1'b1));
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
            input logic [63:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic order_req_t mk_req(logic [TYPE_W-1:0] t, logic [ID_W-1:0] id,
            logic [PX_W-1:0] px, logic [QTY_W-1:0] q);
        order_req_t r;
        r.rtype = t; r.id = id; r.px = px; r.qty = q;
        return r;
    endfunction

    initial clk = 0;
    always #6 clk = ~clk;

    // driver; no idling for items 150 to 229
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 0;
            req_type <= '0;
            order_id <= '0;
            price_tick <= '0;
            order_qty <= '0;
        end
        else if (!start || accepted)
        begin
            if (pending_orders.size() > 0 &&
                ((sent_cnt >= 150 && sent_cnt < 230) || $urandom_range(99) >= 18))
            begin
                order_req_t r;
                r = pending_orders.pop_front();
                book_match(r);
                sent_cnt++;
                start <= 1;
                req_type <= r.rtype;
                order_id <= r.id;
                price_tick <= r.px;
                order_qty <= r.qty;
            end
            else start <= 0;
        end
    end

    always @(posedge clk)
    begin
        accepted <= start && !busy && rst_n;
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (expected_events.size() == 0)
            begin
                $display("unexpected result kind %0d at %0t", event_kind, $realtime);
                errors++;
            end
            else
            begin
                book_event_t e;
                e = expected_events.pop_front();
                if (event_kind !== e.kind) report_mismatch("event_kind", event_kind, e.kind);
                if (buyer_id !== e.buyer) report_mismatch("buyer_id", buyer_id, e.buyer);
                if (seller_id !== e.seller) report_mismatch("seller_id", seller_id, e.seller);
                if (trade_price !== e.price) report_mismatch("trade_price", trade_price, e.price);
                if (trade_qty !== e.qty) report_mismatch("trade_qty", trade_qty, e.qty);
                if (last_of_run !== e.last) report_mismatch("last_of_run", last_of_run, e.last);
            end
        end
    end

    function automatic logic [ID_W-1:0] rand_id();
        if ($urandom_range(3) == 0)
            return ID_W'($urandom());
        return ID_W'($urandom_range(40));
    endfunction

    initial
    begin
        logic [TYPE_W-1:0] t;
        logic [PX_W-1:0] px;
        logic [QTY_W-1:0] q;
        logic [ID_W-1:0] id;
        int u;
        rst_n = 0;
        book_reset();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        queue_req(mk_req(REQ_SELL_CANCEL, 5, 10, 0));
        queue_req(mk_req(REQ_BUY_ADD, 1, 100, 0));
        queue_req(mk_req(REQ_SELL_ADD, 2, 0, 20'hFFFFF));
        queue_req(mk_req(REQ_SELL_ADD, 3, 255, 7));
        queue_req(mk_req(REQ_SELL_ADD, 3, 255, 9));
        queue_req(mk_req(REQ_BUY_ADD, 31'h7FFFFFFF, 255, 20'hFFFFF));
        queue_req(mk_req(REQ_BUY_ADD, 7, 50, 5));
        queue_req(mk_req(REQ_BUY_ADD, 8, 50, 6));
        queue_req(mk_req(REQ_BUY_ADD, 7, 50, 3));
        queue_req(mk_req(REQ_BUY_CANCEL, 7, 50, 0));
        queue_req(mk_req(REQ_BUY_CANCEL, 9, 50, 0));
        queue_req(mk_req(REQ_BUY_CANCEL, 7, 51, 20'hFFFFF));
        queue_req(mk_req(REQ_SELL_ADD, 10, 40, 4));
        queue_req(mk_req(REQ_SELL_CANCEL, 2, 0, 0));
        for (int i = 0; i < 33; i++)
            queue_req(mk_req(REQ_SELL_ADD, ID_W'(100 + i), 200, 1));
        queue_req(mk_req(REQ_BUY_ADD, 11, 255, 40));
        queue_req(mk_req(REQ_BUY_ADD, 12, 255, 40));

        for (int i = 0; i < 330; i++)
        begin
            u = $urandom_range(99);
            t = TYPE_W'($urandom_range(3));
            id = rand_id();
            px = ($urandom_range(9) == 0) ? PX_W'($urandom())
                                          : PX_W'(100 + $urandom_range(15));
            q = ($urandom_range(9) == 0) ? QTY_W'($urandom()) : QTY_W'($urandom_range(60));
            if (u < 30) t[0] = 0;
            queue_req(mk_req(t, id, px, q));
        end

        wait (pending_orders.size() == 0 && !start);
        wait (expected_events.size() == 0 && !busy);
        repeat (200) @(posedge clk);
        if (errors == 0 && expected_events.size() == 0)
            $display("** limit_order_book_matcher_core: PASSED **");
        else
            $display("** limit_order_book_matcher_core: FAILED **");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("** limit_order_book_matcher_core: FAILED **");
        $finish;
    end
endmodule
